@@ src/dts_pkg.sv @@
// Package for the deadline timer scheduler: field widths, codes, reset values.
// No dependencies.
package dts_pkg;
    localparam int TimeW = 63;
    localparam int SlotW = 4;
    localparam int DefaultSlots = 16;
    localparam int CapW = 7;
    localparam int MaxRes = 64;
    localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
    localparam logic [TimeW-1:0] LateLimitRst = 63'd10000000000;
    localparam logic [CapW-1:0] CapRst = 7'd64;

    localparam logic [1:0] OpArmOnce = 2'd0;
    localparam logic [1:0] OpArmPer = 2'd1;
    localparam logic [1:0] OpCancel = 2'd2;
    localparam logic [1:0] OpTick = 2'd3;

    localparam logic [1:0] KindAck = 2'd0;
    localparam logic [1:0] KindFire = 2'd1;
    localparam logic [1:0] KindNone = 2'd2;

    localparam logic [1:0] StOk = 2'd0;
    localparam logic [1:0] StZeroPer = 2'd1;
    localparam logic [1:0] StIdle = 2'd2;

    localparam logic [0:0] RegLate = 1'd0;
    localparam logic [0:0] RegCap = 1'd1;

    // candidate travelling along the chain: earliest due slot so far
    typedef struct packed {
        logic             found;
        logic [TimeW-1:0] dl;
        logic [7:0]       idx;
    } cand_t;

    // command broadcast to every cell
    typedef struct packed {
        logic             arm;
        logic             arm_per;
        logic             cancel;
        logic             fire;
        logic [7:0]       idx;
        logic [TimeW-1:0] dl;
        logic [TimeW-1:0] per;
    } cell_cmd_t;
endpackage

@@ src/dts_if.sv @@
// Valid/ready channel interfaces for input items and results.
// Depends on dts_pkg.
interface dts_in_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               op;
    logic [dts_pkg::SlotW-1:0] slot;
    logic [dts_pkg::TimeW-1:0] deadline;
    logic [dts_pkg::TimeW-1:0] period;
    logic [dts_pkg::TimeW-1:0] now_time;
    modport source (output valid, op, slot, deadline, period, now_time, input ready);
    modport sink (input valid, op, slot, deadline, period, now_time, output ready);
endinterface

interface dts_out_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               kind;
    logic [dts_pkg::SlotW-1:0] fired_slot;
    logic [1:0]               status;
    logic [dts_pkg::TimeW-1:0] fire_deadline;
    logic                     last;
    modport source (output valid, kind, fired_slot, status, fire_deadline, last, input ready);
    modport sink (input valid, kind, fired_slot, status, fire_deadline, last, output ready);
endinterface

@@ src/dts_cell.sv @@
// One timer slot cell: holds deadline, period and flags, and compares its
// due deadline against the candidate from its neighbor. Depends on dts_pkg.
module dts_cell #(
    parameter logic [7:0] IDX = 8'd0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dts_pkg::cell_cmd_t cmd,
    input  logic [dts_pkg::TimeW-1:0] now_time,
    input  dts_pkg::cand_t     cand_in,
    output dts_pkg::cand_t     cand_reg,
    output logic               active
);
    import dts_pkg::*;

    logic [TimeW-1:0] dl_reg, per_reg;
    logic active_reg, periodic_reg;
    logic [TimeW:0] sum;
    logic due, better;

    assign active = active_reg;
    assign sum = {1'b0, dl_reg} + {1'b0, per_reg};
    assign due = active_reg && (dl_reg <= now_time);
    // strict less keeps the lower slot on ties (chain runs low to high)
    assign better = due && (!cand_in.found || dl_reg < cand_in.dl);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            periodic_reg <= 1'b0;
            dl_reg <= '0;
            per_reg <= '0;
            cand_reg <= '0;
        end
        else
        begin
            cand_reg <= better ? cand_t'{found: 1'b1, dl: dl_reg, idx: IDX} : cand_in;
            if (cmd.idx == IDX)
            begin
                if (cmd.arm)
                begin
                    active_reg <= 1'b1;
                    periodic_reg <= cmd.arm_per;
                    dl_reg <= cmd.dl;
                    if (cmd.arm_per)
                        per_reg <= cmd.per;
                end
                else if (cmd.cancel)
                begin
                    active_reg <= 1'b0;
                end
                else if (cmd.fire)
                begin
                    if (periodic_reg)
                        dl_reg <= sum[TimeW] ? TimeMax : sum[TimeW-1:0];
                    else
                        active_reg <= 1'b0;
                end
            end
        end
    end
endmodule

@@ src/deadline_timer_scheduler.sv @@
// Top level of the deadline timer scheduler: config port, control, cell chain.
// Depends on dts_pkg, dts_if, dts_cell.
//
//  channel | dir | contents
//  in      | in  | op, slot, deadline, period, now_time
//  out     | out | kind, fired_slot, status, fire_deadline, last
//  apb     | in  | late_limit (0x0), max_fires_per_tick (0x8)
//
// Arm/cancel: result valid the cycle after the input transfer; the next input
// is taken only once that result has been transferred.
// Tick: the candidate ripples through the chain one cell per cycle, and S_SCAN
// waits for it to pass all TIMER_SLOTS cells. Nothing due, or a cap of one:
// the report follows that scan. Otherwise a fire updates its cell and its
// report is held until a rescan shows whether another slot is due (sets last);
// each further fire is held for a rescan in the same way; a fire that reaches
// the cap is reported without a rescan, with last set. A waiting result stalls
// control and input. Reset clears all slots at once (flip-flops).
module deadline_timer_scheduler #(
    parameter int TIMER_SLOTS = dts_pkg::DefaultSlots
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    dts_in_if.sink      in_ch,
    dts_out_if.source   out_ch
);
    import dts_pkg::*;

    localparam int CntW = $clog2(TIMER_SLOTS + 2);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t state_reg;
    logic [TimeW-1:0] late_reg, now_reg, ctime_reg;
    logic [CapW-1:0] cap_reg, n_reg, cap_eff;
    logic [CntW-1:0] cnt_reg;
    logic pend_found_reg;
    logic [SlotW-1:0] pend_slot_reg;
    logic [TimeW-1:0] pend_dl_reg;
    cell_cmd_t cmd;
    cand_t chain [TIMER_SLOTS+1];
    logic [TIMER_SLOTS-1:0] act;
    logic [2+SlotW+2+TimeW+1-1:0] res_reg;
    logic res_valid_reg;
    logic cfg_wr;
    logic [TimeW:0] late_sum;

    // ---- configuration port ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb
    begin
        case (paddr[3])
            RegLate: prdata = {1'b0, late_reg};
            RegCap: prdata = {57'd0, cap_reg};
            default: prdata = '0;
        endcase
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            late_reg <= LateLimitRst;
            cap_reg <= CapRst;
        end
        else if (cfg_wr && paddr[2:0] == 3'd0)
        begin
            if (paddr[3] == RegLate)
                late_reg <= pwdata[TimeW-1:0];
            else
                cap_reg <= pwdata[CapW-1:0];
        end
    end

    assign cap_eff = (cap_reg == '0) ? 7'd1 : (cap_reg > 7'(MaxRes)) ? 7'(MaxRes) : cap_reg;

    // ---- cell chain: candidate enters at cell 0 and moves up one per cycle ----
    assign chain[0] = '0;
    for (genvar i = 0; i < TIMER_SLOTS; i++)
    begin : g_cell
        dts_cell #(.IDX(8'(i))) u_cell (
            .clk(clk), .rst_n(rst_n), .cmd(cmd), .now_time(now_reg),
            .cand_in(chain[i]), .cand_reg(chain[i+1]), .active(act[i]));
    end
    cand_t win;
    assign win = chain[TIMER_SLOTS];

    // ---- control ----
    assign in_ch.ready = (state_reg == S_IDLE) && !res_valid_reg;
    assign late_sum = {1'b0, in_ch.deadline} + {1'b0, late_reg};
    logic in_xfer, in_ok, arm_ok, cancel_ok, slot_act;
    logic [TimeW-1:0] arm_dl;
    assign in_xfer = in_ch.valid && in_ch.ready;
    assign in_ok = 32'(in_ch.slot) < 32'(TIMER_SLOTS);

    // active flag of the addressed slot
    always_comb
    begin
        slot_act = 1'b0;
        for (int k = 0; k < TIMER_SLOTS; k++)
            if (8'(k) == {{(8-SlotW){1'b0}}, in_ch.slot})
                slot_act = act[k];
    end

    assign arm_ok = in_ok && ((in_ch.op == OpArmOnce) ||
                              (in_ch.op == OpArmPer && in_ch.period != '0));
    assign cancel_ok = in_ok && in_ch.op == OpCancel && slot_act;
    assign arm_dl = (in_ch.op == OpArmPer && {1'b0, ctime_reg} > late_sum) ? ctime_reg
                                                                         : in_ch.deadline;

    always_comb
    begin
        cmd = '0;
        cmd.idx = {{(8-SlotW){1'b0}}, in_ch.slot};
        cmd.dl = arm_dl;
        cmd.per = in_ch.period;
        cmd.arm_per = in_ch.op == OpArmPer;
        if (state_reg == S_IDLE && in_xfer && in_ch.op != OpTick)
        begin
            cmd.arm = arm_ok;
            cmd.cancel = cancel_ok;
        end
        else if (state_reg == S_EMIT)
        begin
            // winner is taken only when no earlier fire is still held and no result waits
            cmd.idx = win.idx;
            cmd.fire = win.found && !res_valid_reg && !pend_found_reg;
        end
    end

    assign out_ch.valid = res_valid_reg;
    assign {out_ch.kind, out_ch.fired_slot, out_ch.status, out_ch.fire_deadline, out_ch.last}
        = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_valid_reg <= 1'b0;
            ctime_reg <= '0;
            now_reg <= '0;
            n_reg <= '0;
            cnt_reg <= '0;
            pend_found_reg <= 1'b0;
            pend_slot_reg <= '0;
            pend_dl_reg <= '0;
            res_reg <= '0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (in_ch.op == OpTick)
                        begin
                            ctime_reg <= in_ch.now_time;
                            now_reg <= in_ch.now_time;
                            n_reg <= '0;
                            cnt_reg <= '0;
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            res_valid_reg <= 1'b1;
                            res_reg <= {KindAck, in_ch.slot,
                                        !in_ok ? StIdle :
                                        (in_ch.op == OpCancel) ? (cancel_ok ? StOk : StIdle) :
                                        arm_ok ? StOk : StZeroPer,
                                        arm_ok ? arm_dl : {TimeW{1'b0}}, 1'b1};
                        end
                    end
                end
                S_SCAN:
                begin
                    // wait for the candidate to ripple through all cells
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CntW'(TIMER_SLOTS - 1))
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!res_valid_reg)
                    begin
                        if (pend_found_reg)
                        begin
                            // held fire goes out; it is last when nothing more is due
                            res_valid_reg <= 1'b1;
                            res_reg <= {KindFire, pend_slot_reg, StOk, pend_dl_reg, !win.found};
                            pend_found_reg <= 1'b0;
                            if (!win.found)
                                state_reg <= S_IDLE;
                        end
                        else if (!win.found)
                        begin
                            res_valid_reg <= 1'b1;
                            res_reg <= {KindNone, {SlotW{1'b0}}, StOk, {TimeW{1'b0}}, 1'b1};
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            n_reg <= n_reg + 1'b1;
                            if (n_reg + 1'b1 == cap_eff)
                            begin
                                // cap reached: this fire closes the tick
                                res_valid_reg <= 1'b1;
                                res_reg <= {KindFire, win.idx[SlotW-1:0], StOk, win.dl, 1'b1};
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                // hold the fire and rescan with the winner updated
                                pend_found_reg <= 1'b1;
                                pend_slot_reg <= win.idx[SlotW-1:0];
                                pend_dl_reg <= win.dl;
                                cnt_reg <= '0;
                                state_reg <= S_SCAN;
                            end
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // payload holds while a result waits
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res_reg));
    // input only taken while idle
    a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == S_IDLE);
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg));
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.kind == KindAck || out_ch.kind == KindFire ||
                          out_ch.kind == KindNone));
endmodule

@@ tb/deadline_timer_scheduler_test.sv @@
// Self-checking testbench for the deadline timer scheduler: directed and random
// arm/cancel/tick transfers, APB register phases, scoreboard on the result channel.
// Depends on dts_pkg, dts_if and the RTL top level.
module deadline_timer_scheduler_test;
    import dts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]       op;
        logic [SlotW-1:0] slot;
        logic [TimeW-1:0] deadline;
        logic [TimeW-1:0] period;
        logic [TimeW-1:0] now_time;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [SlotW-1:0] fired_slot;
        logic [1:0]       status;
        logic [TimeW-1:0] fire_deadline;
        logic             last;
    } rpt_t;

    localparam int NSlots = DefaultSlots;
    localparam longint CycleLimit = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    dts_in_if  in_ch ();
    dts_out_if out_ch ();

    deadline_timer_scheduler u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the scheduler state
    logic [TimeW-1:0] sh_deadline [NSlots];
    logic [TimeW-1:0] sh_period [NSlots];
    logic             sh_active [NSlots];
    logic             sh_periodic [NSlots];
    logic [TimeW-1:0] sh_now;
    logic [TimeW-1:0] sh_late;
    logic [CapW-1:0]  sh_cap;

    cmd_t   pending_cmds [$];
    rpt_t   expected_rpts [$];
    int     errors = 0;
    longint cycles = 0;
    bit     hold_sink = 1'b0;   // long receiver hold-off request
    bit     pause_src = 1'b0;   // sender drain request

    task automatic report_mismatch(input string what, input rpt_t got, input rpt_t exp_r);
        $display("mismatch %s: got k%0d s%0d st%0d dl%0d l%0d exp k%0d s%0d st%0d dl%0d l%0d",
                 what, got.kind, got.fired_slot, got.status, got.fire_deadline, got.last,
                 exp_r.kind, exp_r.fired_slot, exp_r.status, exp_r.fire_deadline,
                 exp_r.last);
        errors++;
    endtask

    function automatic void queue_cmd(input cmd_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    function automatic void expect_rpt(input rpt_t r);
        expected_rpts.insert(expected_rpts.size(), r);
    endfunction

    function automatic rpt_t mk(logic [1:0] k, logic [SlotW-1:0] s, logic [1:0] st,
                                logic [TimeW-1:0] dl, logic l);
        rpt_t r;
        r.kind = k; r.fired_slot = s; r.status = st; r.fire_deadline = dl; r.last = l;
        return r;
    endfunction

    // compute the results of one accepted command and update the shadow state
    task automatic schedule_step(input cmd_t c);
        int cap, n, best, i;
        logic [TimeW-1:0] dl;
        logic [TimeW:0] sum;
        if (c.op == OpTick)
        begin
            cap = (sh_cap == 0) ? 1 : (sh_cap > MaxRes ? MaxRes : int'(sh_cap));
            sh_now = c.now_time;
            n = 0;
            while (n < cap)
            begin
                best = -1;
                for (i = 0; i < NSlots; i++)
                    if (sh_active[i] && sh_deadline[i] <= c.now_time)
                        if (best < 0 || sh_deadline[i] < sh_deadline[best])
                            best = i;
                if (best < 0)
                    break;
                expect_rpt(mk(KindFire, SlotW'(best), StOk, sh_deadline[best], 1'b0));
                n++;
                if (sh_periodic[best])
                begin
                    sum = {1'b0, sh_deadline[best]} + {1'b0, sh_period[best]};
                    sh_deadline[best] = sum[TimeW] ? TimeMax : sum[TimeW-1:0];
                end
                else
                    sh_active[best] = 1'b0;
            end
            if (n == 0)
                expect_rpt(mk(KindNone, '0, StOk, '0, 1'b1));
            else
                expected_rpts[$].last = 1'b1;
        end
        else if (c.op == OpCancel)
        begin
            expect_rpt(mk(KindAck, c.slot, sh_active[c.slot] ? StOk : StIdle, '0, 1'b1));
            sh_active[c.slot] = 1'b0;
        end
        else if (c.op == OpArmPer && c.period == 0)
            expect_rpt(mk(KindAck, c.slot, StZeroPer, '0, 1'b1));
        else
        begin
            dl = c.deadline;
            if (c.op == OpArmPer)
            begin
                // sum in 64 bits never wraps
                sum = {1'b0, dl} + {1'b0, sh_late};
                if ({1'b0, sh_now} > sum)
                    dl = sh_now;
                sh_period[c.slot] = c.period;
                sh_periodic[c.slot] = 1'b1;
            end
            else
                sh_periodic[c.slot] = 1'b0;
            sh_deadline[c.slot] = dl;
            sh_active[c.slot] = 1'b1;
            expect_rpt(mk(KindAck, c.slot, StOk, dl, 1'b1));
        end
    endtask

    function automatic logic [TimeW-1:0] rand_time();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return TimeMax;
            2: return TimeW'({$urandom, $urandom});
            default: return TimeW'($urandom_range(0, 4000));
        endcase
    endfunction

    function automatic cmd_t mk_cmd(logic [1:0] op, int s, logic [TimeW-1:0] dl,
                                    logic [TimeW-1:0] per, logic [TimeW-1:0] nt);
        cmd_t c;
        c.op = op; c.slot = SlotW'(s); c.deadline = dl; c.period = per; c.now_time = nt;
        return c;
    endfunction

    // driver: offers pending commands with random gaps
    int gap_cnt = 0;
    always @(posedge clk)
    begin
        cmd_t c;
        cycles <= cycles + 1;
        if (in_ch.valid && in_ch.ready)
        begin
            c = {in_ch.op, in_ch.slot, in_ch.deadline, in_ch.period, in_ch.now_time};
            schedule_step(c);
            void'(pending_cmds.pop_front());
            gap_cnt = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        end
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (in_ch.valid && !in_ch.ready)
            ;  // hold offer until taken
        else if (pause_src)
            in_ch.valid <= 1'b0;
        else if (gap_cnt > 0)
        begin
            gap_cnt--;
            in_ch.valid <= 1'b0;
        end
        else if (pending_cmds.size() > 0)
        begin
            // front entry is the one to drive next (popped on transfer above)
            c = pending_cmds[0];
            in_ch.valid    <= 1'b1;
            in_ch.op       <= c.op;
            in_ch.slot     <= c.slot;
            in_ch.deadline <= c.deadline;
            in_ch.period   <= c.period;
            in_ch.now_time <= c.now_time;
        end
        else
            in_ch.valid <= 1'b0;
    end

    // monitor: random stalls, compares against oldest expectation
    int stall_cnt = 0;
    always @(posedge clk)
    begin
        rpt_t got;
        if (out_ch.valid && out_ch.ready)
        begin
            got = {out_ch.kind, out_ch.fired_slot, out_ch.status, out_ch.fire_deadline,
                   out_ch.last};
            if (expected_rpts.size() == 0)
                report_mismatch("unexpected", got, '0);
            else if (got !== expected_rpts[0])
                report_mismatch("field", got, expected_rpts.pop_front());
            else
                void'(expected_rpts.pop_front());
            stall_cnt = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        end
        if (hold_sink || !rst_n)
            out_ch.ready <= 1'b0;
        else if (stall_cnt > 0)
        begin
            stall_cnt--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
        if (cycles > CycleLimit)
        begin
            $display("TB_ERROR");
            $finish;
        end

    // APB write: setup then access; pready is tied high
    task automatic reg_write(input logic [0:0] idx, input logic [63:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 4'(idx) << 3; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == RegLate)
            sh_late = val[TimeW-1:0];
        else
            sh_cap = val[CapW-1:0];
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || in_ch.valid || expected_rpts.size() > 0)
            @(posedge clk);
        // let the last handshake settle
        repeat (4) @(posedge clk);
    endtask

    task automatic add_random(input int count);
        int k, s;
        for (k = 0; k < count; k++)
        begin
            s = $urandom_range(0, NSlots - 1);
            case ($urandom_range(0, 9))
                0, 1, 2: queue_cmd(mk_cmd(OpArmOnce, s,
                    $urandom_range(0, 1) ? TimeW'($urandom_range(0, 3000)) : rand_time(),
                    rand_time(), rand_time()));
                3, 4: queue_cmd(mk_cmd(OpArmPer, s, rand_time(),
                    $urandom_range(0, 7) == 0 ? '0 : ($urandom_range(0, 3) == 0 ?
                    rand_time() : TimeW'($urandom_range(1, 500))), rand_time()));
                5: queue_cmd(mk_cmd(OpCancel, s, rand_time(), rand_time(),
                    rand_time()));
                default: queue_cmd(mk_cmd(OpTick, s, rand_time(),
                    rand_time(), $urandom_range(0, 5) == 0 ? rand_time() :
                    TimeW'($urandom_range(0, 4000))));
            endcase
        end
    endtask

    initial
    begin
        int i;
        for (i = 0; i < NSlots; i++)
        begin
            sh_deadline[i] = '0; sh_period[i] = '0;
            sh_active[i] = 1'b0; sh_periodic[i] = 1'b0;
        end
        sh_now = '0; sh_late = LateLimitRst; sh_cap = CapRst;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every op, each special case
        queue_cmd(mk_cmd(OpTick, 0, 0, 0, 0));                 // nothing due
        queue_cmd(mk_cmd(OpCancel, 3, 0, 0, 0));               // idle cancel
        queue_cmd(mk_cmd(OpArmPer, 15, 5, 0, 0));              // zero period
        queue_cmd(mk_cmd(OpArmOnce, 0, TimeMax, TimeMax, TimeMax));
        queue_cmd(mk_cmd(OpArmOnce, 1, 10, 0, 0));
        queue_cmd(mk_cmd(OpArmOnce, 2, 10, 0, 0));             // tie
        queue_cmd(mk_cmd(OpArmPer, 3, 4, 3, 0));               // fires three times
        queue_cmd(mk_cmd(OpArmOnce, 1, 7, 0, 0));              // overwrite
        queue_cmd(mk_cmd(OpTick, 0, 0, 0, 12));
        queue_cmd(mk_cmd(OpCancel, 3, 0, 0, 0));
        queue_cmd(mk_cmd(OpArmPer, 4, TimeMax - 2, TimeMax, 0)); // saturate
        queue_cmd(mk_cmd(OpTick, 0, 0, 0, TimeMax));
        queue_cmd(mk_cmd(OpTick, 0, 0, 0, 100));               // backwards
        queue_cmd(mk_cmd(OpArmPer, 5, 0, TimeMax, 0));
        queue_cmd(mk_cmd(OpCancel, 4, 0, 0, 0));
        queue_cmd(mk_cmd(OpCancel, 5, 0, 0, 0));
        wait_idle();

        // late limit small: old periodic start gets corrected
        reg_write(RegLate, 64'd5);
        reg_write(RegCap, 64'd0);                              // acts as 1
        queue_cmd(mk_cmd(OpTick, 0, 0, 0, 1000));
        queue_cmd(mk_cmd(OpArmPer, 6, 900, 50, 0));            // corrected
        queue_cmd(mk_cmd(OpArmPer, 7, 996, 1, 0));             // not corrected
        queue_cmd(mk_cmd(OpArmOnce, 8, 0, 0, 0));
        queue_cmd(mk_cmd(OpTick, 0, 0, 0, 1000));
        queue_cmd(mk_cmd(OpTick, 0, 0, 0, 1000));
        wait_idle();

        reg_write(RegCap, 64'h7F);                             // acts as 64
        reg_write(RegLate, {1'b0, TimeMax});
        queue_cmd(mk_cmd(OpTick, 0, 0, 0, 2000));              // many repeats
        wait_idle();

        // random phases under several settings
        reg_write(RegCap, 64'd3);
        reg_write(RegLate, 64'd0);
        add_random(50);
        // long receiver hold-off while the sender keeps offering
        hold_sink = 1'b1;
        repeat (400) @(posedge clk);
        hold_sink = 1'b0;
        wait_idle();

        reg_write(RegCap, 64'd1);
        reg_write(RegLate, 64'd1000);
        add_random(50);
        wait_idle();

        reg_write(RegCap, 64'd64);
        reg_write(RegLate, LateLimitRst);
        add_random(20);
        // sender pause until every expected result has come
        while (pending_cmds.size() > 10)
            @(posedge clk);
        pause_src = 1'b1;
        while (expected_rpts.size() > 0 || in_ch.valid)
            @(posedge clk);
        pause_src = 1'b0;
        add_random(20);
        wait_idle();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
